/* hdl/lsfp_pkg.sv */
// Package for the laser scan frame parser.
// It holds the frame layout constants, the field widths and the types that
// the controller and the datapath exchange. It depends on nothing.
package lsfp_pkg;

  // Frame layout.
  localparam int unsigned PACKETS_PER_FRAME   = 60;
  localparam int unsigned PACKET_BYTES        = 42;
  localparam int unsigned READINGS_PER_PACKET = 6;
  localparam int unsigned FIRST_SLOT_OFF      = 7;
  localparam int unsigned SLOT_STEP           = 6;
  localparam int unsigned HDR_FIRST_OFF       = 0;
  localparam int unsigned HDR_SECOND_OFF      = 1;
  localparam int unsigned SPEED_HIGH_OFF      = 3;
  localparam int unsigned FRAME_START_OFF     = 2;
  localparam int unsigned LAST_OFF            = PACKET_BYTES - 1;

  // Sync bytes and scaling.
  localparam logic [7:0]  SYNC_FIRST  = 8'hFA;
  localparam logic [7:0]  SYNC_SECOND = 8'hA0;
  localparam int unsigned TOP_ANGLE   = 359;
  localparam int unsigned RPM_DIVISOR = 10;

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ANGLE_W  = 9;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned RPM_W    = 13;
  localparam int unsigned GOOD_W   = 6;
  localparam int unsigned SUM_W    = 22;
  localparam int unsigned HELD_W   = 24;

  // Internal widths.
  localparam int unsigned OFF_W = $clog2(PACKET_BYTES);
  localparam int unsigned PKT_W = (PACKETS_PER_FRAME > 1) ? $clog2(PACKETS_PER_FRAME) : 1;
  localparam int unsigned DIVISOR_W = $clog2(RPM_DIVISOR * PACKETS_PER_FRAME + 1);
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Result kinds.
  localparam logic KIND_READING  = 1'b0;
  localparam logic KIND_SCAN_END = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic shift;         // an input item was accepted
    logic frame_start;   // sync pair found, open a frame
    logic frame_step;    // an item inside the frame was accepted
    logic emit_reading;  // load a range reading into the output register
    logic div_start;     // last item of the frame, start the rpm division
    logic emit_end;      // load the end-of-scan result
  } lsfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic slot;
    logic last;
    logic pkt_valid;
    logic div_busy;
    logic div_done;
    logic out_free;
  } lsfp_stat_t;

  // True when a packet offset is the last byte of one of the readings.
  function automatic logic is_slot(input logic [OFF_W-1:0] off);
    logic hit;
    hit = 1'b0;
    for (int unsigned i = 0; i < READINGS_PER_PACKET; i++) begin
      if (off == OFF_W'(FIRST_SLOT_OFF + i * SLOT_STEP)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* hdl/lsfp_ifs.sv */
// Channel interfaces of the laser scan frame parser: the received byte
// stream and the result stream. Depends on lsfp_pkg.
interface lsfp_rx_if;
  import lsfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lsfp_res_if;
  import lsfp_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [ANGLE_W-1:0] angle;
  logic [WORD_W-1:0]  range_mm;
  logic [WORD_W-1:0]  intensity;
  logic [RPM_W-1:0]   rpm;
  logic [GOOD_W-1:0]  good_packets;

  modport source (output valid, output kind, output angle, output range_mm,
                  output intensity, output rpm, output good_packets, input ready);
  modport sink (input valid, input kind, input angle, input range_mm,
                input intensity, input rpm, input good_packets, output ready);
endinterface

/* hdl/lsfp_div.sv */
// Restoring divider for the rpm figure, one quotient bit per cycle.
// Depends on lsfp_pkg.
module lsfp_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            ack_i,
  input  logic [lsfp_pkg::SUM_W-1:0]      dividend_i,
  input  logic [lsfp_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [lsfp_pkg::SUM_W-1:0]      quotient_o
);
  import lsfp_pkg::*;

  logic [SUM_W-1:0]     quo_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // One trial subtraction of the shifted remainder.
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign diff    = shifted - {1'b0, dvs_q};

  // Control: busy from start until the result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy_q && (cnt_q != '0)) begin
      cnt_q <= cnt_q - 1'b1;
    end else if (ack_i) begin
      busy_q <= 1'b0;
    end
  end

  // Quotient and remainder shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == '0);
  // A zero divisor (no good packet) reads as zero.
  assign quotient_o = (dvs_q == '0) ? '0 : quo_q;

endmodule

/* hdl/lsfp_ctrl.sv */
// Controller of the laser scan frame parser: sync hunt, frame and division
// states, and the commands for the datapath. Depends on lsfp_pkg.
module lsfp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lsfp_pkg::lsfp_stat_t  stat_i,
  output lsfp_pkg::lsfp_cmd_t   cmd_o
);
  import lsfp_pkg::*;

  typedef enum logic [3:0] {
    ST_HUNT1 = 4'b0001,
    ST_HUNT2 = 4'b0010,
    ST_FRAME = 4'b0100,
    ST_DIV   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  // Items are taken in every state but the division, when the output has room.
  assign in_ready_o = (state_q != ST_DIV) && stat_i.out_free;
  assign fire       = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.shift = fire;
    unique case (state_q)
      ST_HUNT1: begin
        if (fire && stat_i.is_sync1) begin
          state_d = ST_HUNT2;
        end
      end
      ST_HUNT2: begin
        if (fire) begin
          if (stat_i.is_sync2) begin
            state_d           = ST_FRAME;
            cmd_o.frame_start = 1'b1;
          end else begin
            state_d = ST_HUNT1;
          end
        end
      end
      ST_FRAME: begin
        if (fire) begin
          cmd_o.frame_step   = 1'b1;
          cmd_o.emit_reading = stat_i.slot && stat_i.pkt_valid;
          if (stat_i.last) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (stat_i.div_done && stat_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d        = ST_HUNT1;
        end
      end
      default: begin
        state_d = ST_HUNT1;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/lsfp_datapath.sv */
// Datapath of the laser scan frame parser: frame counters, held bytes,
// speed sum, rpm divider and the output register. Depends on lsfp_pkg,
// lsfp_res_if and lsfp_div.
module lsfp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lsfp_pkg::BYTE_W-1:0] rx_byte_i,
  input  lsfp_pkg::lsfp_cmd_t         cmd_i,
  output lsfp_pkg::lsfp_stat_t        stat_o,
  lsfp_res_if.source                  res_o
);
  import lsfp_pkg::*;

  logic [OFF_W-1:0]     off_q;
  logic [PKT_W-1:0]     pkt_q;
  logic                 pkt_valid_q;
  logic [GOOD_W-1:0]    good_q;
  logic [SUM_W-1:0]     sum_q;
  logic [ANGLE_W-1:0]   angle_q;
  logic [HELD_W-1:0]    held_q;
  logic                 hdr_ok;
  logic                 slot;
  logic                 last;
  logic                 div_busy;
  logic                 div_done;
  logic [SUM_W-1:0]     quotient;
  logic [DIVISOR_W-1:0] divisor;
  logic                 out_v_q;
  logic                 out_free;
  logic                 kind_q;
  logic [ANGLE_W-1:0]   angle_out_q;
  logic [WORD_W-1:0]    range_q;
  logic [WORD_W-1:0]    inten_q;
  logic [RPM_W-1:0]     rpm_q;
  logic [GOOD_W-1:0]    good_out_q;

  // Byte decode against the frame position.
  assign hdr_ok   = (rx_byte_i == (SYNC_SECOND + BYTE_W'(pkt_q)));
  assign slot     = is_slot(off_q);
  assign last     = (pkt_q == PKT_W'(PACKETS_PER_FRAME - 1)) && (off_q == OFF_W'(LAST_OFF));
  assign out_free = !out_v_q || res_o.ready;

  assign stat_o.is_sync1  = (rx_byte_i == SYNC_FIRST);
  assign stat_o.is_sync2  = (rx_byte_i == SYNC_SECOND);
  assign stat_o.slot      = slot;
  assign stat_o.last      = last;
  assign stat_o.pkt_valid = pkt_valid_q;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = out_free;

  // Frame position and per-packet bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      pkt_q       <= '0;
      pkt_valid_q <= 1'b0;
      good_q      <= '0;
      sum_q       <= '0;
      angle_q     <= '0;
    end else if (cmd_i.frame_start) begin
      off_q       <= OFF_W'(FRAME_START_OFF);
      pkt_q       <= '0;
      pkt_valid_q <= 1'b1;
      good_q      <= GOOD_W'(1);
      sum_q       <= '0;
      angle_q     <= ANGLE_W'(TOP_ANGLE);
    end else if (cmd_i.frame_step) begin
      if (off_q == OFF_W'(HDR_FIRST_OFF)) begin
        pkt_valid_q <= stat_o.is_sync1;
      end else if (off_q == OFF_W'(HDR_SECOND_OFF)) begin
        if (pkt_valid_q && hdr_ok) begin
          good_q <= good_q + 1'b1;
        end else begin
          pkt_valid_q <= 1'b0;
        end
      end else if (off_q == OFF_W'(SPEED_HIGH_OFF)) begin
        if (pkt_valid_q) begin
          sum_q <= sum_q + SUM_W'({rx_byte_i, held_q[7:0]});
        end
      end
      // Every reading slot moves the angle down until it reaches zero, counted or not.
      if (slot && (angle_q != '0)) begin
        angle_q <= angle_q - 1'b1;
      end
      if (last) begin
        off_q <= '0;
        pkt_q <= '0;
      end else if (off_q == OFF_W'(LAST_OFF)) begin
        off_q <= '0;
        pkt_q <= pkt_q + 1'b1;
      end else begin
        off_q <= off_q + 1'b1;
      end
    end
  end

  // The last three received bytes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      held_q <= {held_q[HELD_W-BYTE_W-1:0], rx_byte_i};
    end
  end

  // rpm = speed sum / (good packets * 10).
  assign divisor = DIVISOR_W'(good_q) * DIVISOR_W'(RPM_DIVISOR);

  lsfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .ack_i      (cmd_i.emit_end),
    .dividend_i (sum_q),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.emit_reading || cmd_i.emit_end) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_end) begin
      kind_q      <= KIND_SCAN_END;
      angle_out_q <= '0;
      range_q     <= '0;
      inten_q     <= '0;
      rpm_q       <= quotient[RPM_W-1:0];
      good_out_q  <= good_q;
    end else if (cmd_i.emit_reading) begin
      kind_q      <= KIND_READING;
      angle_out_q <= angle_q;
      range_q     <= {rx_byte_i, held_q[7:0]};
      inten_q     <= {held_q[15:8], held_q[23:16]};
      rpm_q       <= '0;
      good_out_q  <= '0;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.kind         = kind_q;
  assign res_o.angle        = angle_out_q;
  assign res_o.range_mm     = range_q;
  assign res_o.intensity    = inten_q;
  assign res_o.rpm          = rpm_q;
  assign res_o.good_packets = good_out_q;

endmodule

/* hdl/lidar_scan_frame_parser.sv */
// Laser scan frame parser, top level. One received byte per cycle while the
// output register is free; a result waiting there blocks the input. A range
// reading appears in the output register in the cycle after its last byte is taken.
// After the last byte of a frame the rpm divider forms the quotient one bit per step;
// the end-of-scan result loads once it is done and the output register is free, and
// no byte is taken meanwhile (the input stalls once per 2520-byte frame).
// Reset (asynchronous, active low) returns to the sync hunt with no result held.
module lidar_scan_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsfp_rx_if.sink    rx_i,
  lsfp_res_if.source res_o
);
  import lsfp_pkg::*;

  lsfp_cmd_t  cmd;
  lsfp_stat_t stat;
  logic       in_ready;

  assign rx_i.ready = in_ready;

  lsfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsfp_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_i.rx_byte),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .res_o     (res_o)
  );

  // No byte is taken while the rpm division is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat.div_busy |-> !in_ready)
    else $error("byte accepted during rpm division");

  // Starting the division makes the divider busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");

  // An end-of-scan result always counts at least one good packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_o.valid && (res_o.kind == KIND_SCAN_END)) |-> (res_o.good_packets != '0))
    else $error("end of scan with no good packet");

  // A reading and the end-of-scan result are never loaded together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit_end |-> !cmd.emit_reading)
    else $error("two results loaded in one cycle");

endmodule
